[rtl/alid_pkg.sv]
package alid_pkg;

  localparam int CAPACITY = 16;
  localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int LEN_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 5;
  localparam int VALUE_W  = 32;
  localparam int COUNT_W  = 5;
  // wide enough for length + 1 and the position side by side
  localparam int CMP_W    = ((LEN_W > POS_W) ? LEN_W : POS_W) + 1;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_DELETE = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_READ,
    S_INS_DRAIN,
    S_PLACE,
    S_DEL_HEAD,
    S_DEL_READ,
    S_DEL_DRAIN,
    S_CLEAR,
    S_DONE
  } seq_state_t;

  typedef struct packed {
    logic               re;
    logic [ADDR_W-1:0]  raddr;
    logic               we;
    logic [ADDR_W-1:0]  waddr;
    logic [VALUE_W-1:0] wdata;
  } mem_cmd_t;

  typedef struct packed {
    logic               accepted;
    logic [VALUE_W-1:0] removed_value;
    logic [COUNT_W-1:0] count_after;
  } result_t;

endpackage

[rtl/alid_ram.sv]
module alid_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/alid_seq.sv]
module alid_seq
  import alid_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               kind,
  input  logic [POS_W-1:0]   position,
  input  logic [VALUE_W-1:0] new_value,
  output mem_cmd_t           mem_cmd,
  input  logic [VALUE_W-1:0] rdata,
  output logic               res_valid,
  input  logic               res_ready,
  output result_t            res
);

  seq_state_t         state, state_next;
  logic [LEN_W-1:0]   len;
  logic [ADDR_W-1:0]  ptr;
  logic [ADDR_W-1:0]  pos_m1;
  logic [ADDR_W-1:0]  top;
  logic [VALUE_W-1:0] value;
  logic [VALUE_W-1:0] removed;
  logic               ok;
  logic               pend_valid;
  logic [ADDR_W-1:0]  pend_addr;
  logic               head_pend;

  logic [CMP_W-1:0]   pos_ext;
  logic [CMP_W-1:0]   len_ext;
  logic               item_ok;
  logic               has_shift;
  logic               accept;

  assign pos_ext = CMP_W'(position);
  assign len_ext = CMP_W'(len);
  // insert position may be one past the end; delete must hit an element
  assign has_shift = pos_ext <= len_ext;
  assign item_ok = (position != '0) &&
                   ((kind == KIND_INSERT) ?
                    ((pos_ext <= len_ext + CMP_W'(1)) && (len_ext < CMP_W'(CAPACITY))) :
                    has_shift);
  assign accept = in_valid && in_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (!item_ok) begin
            state_next = S_DONE;
          end else if (kind == KIND_INSERT) begin
            state_next = has_shift ? S_INS_READ : S_PLACE;
          end else begin
            state_next = S_DEL_HEAD;
          end
        end
      end
      S_INS_READ:  state_next = (ptr == pos_m1) ? S_INS_DRAIN : S_INS_READ;
      S_INS_DRAIN: state_next = S_PLACE;
      S_PLACE:     state_next = S_DONE;
      S_DEL_HEAD:  state_next = (pos_m1 == top) ? S_CLEAR : S_DEL_READ;
      S_DEL_READ:  state_next = (ptr == top) ? S_DEL_DRAIN : S_DEL_READ;
      S_DEL_DRAIN: state_next = S_CLEAR;
      S_CLEAR:     state_next = S_DONE;
      S_DONE:      state_next = res_ready ? S_IDLE : S_DONE;
      default:     state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    res_valid     = 1'b0;
    mem_cmd.re    = 1'b0;
    mem_cmd.raddr = ptr;
    mem_cmd.we    = pend_valid;
    mem_cmd.waddr = pend_addr;
    mem_cmd.wdata = rdata;
    unique case (state)
      S_IDLE: in_ready = 1'b1;
      S_INS_READ, S_DEL_READ: mem_cmd.re = 1'b1;
      S_DEL_HEAD: begin
        mem_cmd.re    = 1'b1;
        mem_cmd.raddr = pos_m1;
      end
      S_PLACE: begin
        mem_cmd.we    = 1'b1;
        mem_cmd.waddr = pos_m1;
        mem_cmd.wdata = value;
      end
      S_CLEAR: begin
        mem_cmd.we    = 1'b1;
        mem_cmd.waddr = top;
        mem_cmd.wdata = '0;
      end
      S_DONE: res_valid = 1'b1;
      default: ;
    endcase
    res.accepted      = ok;
    res.removed_value = removed;
    res.count_after   = len_ext[COUNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      len        <= '0;
      pend_valid <= 1'b0;
      head_pend  <= 1'b0;
    end else begin
      state      <= state_next;
      // a read issued in a shift state lands one slot over on the next cycle
      pend_valid <= (state == S_INS_READ) || (state == S_DEL_READ);
      head_pend  <= (state == S_DEL_HEAD);
      if (state == S_PLACE) begin
        len <= len + LEN_W'(1);
      end else if (state == S_CLEAR) begin
        len <= len - LEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_addr <= (state == S_INS_READ) ? ptr + ADDR_W'(1) : ptr - ADDR_W'(1);
    if (head_pend) begin
      removed <= rdata;
    end
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          value   <= new_value;
          pos_m1  <= ADDR_W'(pos_ext - CMP_W'(1));
          top     <= ADDR_W'(len_ext - CMP_W'(1));
          ptr     <= ADDR_W'(len_ext - CMP_W'(1));
          removed <= '0;
          ok      <= item_ok;
        end
      end
      S_INS_READ: ptr <= ptr - ADDR_W'(1);
      S_DEL_HEAD: ptr <= pos_m1 + ADDR_W'(1);
      S_DEL_READ: ptr <= ptr + ADDR_W'(1);
      default: ;
    endcase
  end

  a_no_rw_same_entry: assert property (@(posedge clk) disable iff (rst)
    mem_cmd.we && mem_cmd.re |-> mem_cmd.waddr != mem_cmd.raddr)
    else $error("read and write to the same entry in one cycle");

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    len_ext <= CMP_W'(CAPACITY))
    else $error("length above capacity");

  a_len_step: assert property (@(posedge clk) disable iff (rst)
    !$stable(len) |-> (len == $past(len) + 1) || (len + 1 == $past(len)))
    else $error("length moved by more than one");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != S_IDLE)
    else $error("accepted item left no work");

endmodule

[rtl/array_list_insert_delete_core.sv]
// operation: an insert or delete moves the affected elements one slot through the RAM, then
//   offers its result; a rejected item is answered without touching the RAM
// throughput: one item at a time, set by the one-entry-per-cycle shift through the
//   element RAM (one read and one write port)
// reset: rst clears the length and all control state; ram contents are left as is,
//   since only entries below the length are ever read
module array_list_insert_delete_core
  import alid_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // position[4:0], new_value[36:5], zero pad
  input  logic        s_tuser,   // kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // removed_value[31:0], count_after[36:32], zero pad
  output logic        m_tuser    // accepted
);

  mem_cmd_t           mem_cmd;
  logic [VALUE_W-1:0] rdata;
  logic               res_valid;
  logic               res_ready;
  result_t            res;
  result_t            out_res;

  alid_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .kind      (s_tuser),
    .position  (s_tdata[POS_W-1:0]),
    .new_value (s_tdata[POS_W+VALUE_W-1:POS_W]),
    .mem_cmd   (mem_cmd),
    .rdata     (rdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  alid_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (mem_cmd.we),
    .waddr (mem_cmd.waddr),
    .wdata (mem_cmd.wdata),
    .re    (mem_cmd.re),
    .raddr (mem_cmd.raddr),
    .rdata (rdata)
  );

  // output holding register
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res <= res;
    end
  end

  assign m_tuser = out_res.accepted;
  assign m_tdata = {3'b000, out_res.count_after, out_res.removed_value};

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps

module tb
  import alid_pkg::*;
;

  localparam int RANDOM_ITEMS = 1000;
  localparam int STALL_LIMIT  = 2000;
  localparam int TAIL_CYCLES  = 40;
  localparam int DIR_ROWS     = 26;

  typedef struct {
    logic               kind;
    logic [POS_W-1:0]   pos;
    logic [VALUE_W-1:0] val;
    bit                 typed;
    logic               acc;
    logic [COUNT_W-1:0] cnt;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic        s_tuser = KIND_INSERT;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        m_tuser;

  // shadow copy of the list
  logic [VALUE_W-1:0] list_mem [CAPACITY];
  int                 list_len;

  result_t   expected_results [$];
  stim_row_t dir_rows [DIR_ROWS];
  int        errors = 0;
  int        quiet_cycles = 0;
  bit        no_gaps = 1'b0;

  array_list_insert_delete_core DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic result_t list_apply(logic kind, logic [POS_W-1:0] pos,
                                         logic [VALUE_W-1:0] val);
    result_t r;
    int p;
    int j;
    p = int'(pos);
    r = '0;
    if (kind == KIND_INSERT) begin
      if (p >= 1 && p <= list_len + 1 && list_len < CAPACITY) begin
        for (j = list_len; j >= p; j--) list_mem[j] = list_mem[j-1];
        list_mem[p-1] = val;
        list_len++;
        r.accepted = 1'b1;
      end
    end else begin
      if (p >= 1 && p <= list_len) begin
        r.removed_value = list_mem[p-1];
        for (j = p; j < list_len; j++) list_mem[j-1] = list_mem[j];
        list_mem[list_len-1] = '0;
        list_len--;
        r.accepted = 1'b1;
      end
    end
    r.count_after = list_len[COUNT_W-1:0];
    return r;
  endfunction

  function automatic stim_row_t dir_row(logic kind, int pos, logic [VALUE_W-1:0] val,
                                        bit typed, logic acc, int cnt);
    stim_row_t r;
    r.kind  = kind;
    r.pos   = pos[POS_W-1:0];
    r.val   = val;
    r.typed = typed;
    r.acc   = acc;
    r.cnt   = cnt[COUNT_W-1:0];
    return r;
  endfunction

  // drive one item, hold it until the transfer, then predict its result
  task automatic send_op(logic kind, logic [POS_W-1:0] pos, logic [VALUE_W-1:0] val,
                         bit typed, result_t want);
    result_t got;
    if (!no_gaps && $urandom_range(99) < 14) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {3'b000, val, pos};
    do @(posedge clk); while (!s_tready);
    got = list_apply(kind, pos, val);
    expected_results.push_back(typed ? want : got);
  endtask

  // result side stalls
  always @(posedge clk) begin
    m_tready <= no_gaps || ($urandom_range(99) >= 14);
  end

  always @(posedge clk) begin
    result_t want;
    if (m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        $error("result transfer with nothing expected: accepted %0d removed %h count %0d",
               m_tuser, m_tdata[31:0], m_tdata[36:32]);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (m_tuser !== want.accepted) begin
          $error("accepted: expected %0d, got %0d", want.accepted, m_tuser);
          errors++;
        end
        if (m_tdata[31:0] !== want.removed_value) begin
          $error("removed_value: expected %h, got %h", want.removed_value, m_tdata[31:0]);
          errors++;
        end
        if (m_tdata[36:32] !== want.count_after) begin
          $error("count_after: expected %0d, got %0d", want.count_after, m_tdata[36:32]);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    result_t want;
    logic    kind;
    logic [POS_W-1:0]   pos;
    logic [VALUE_W-1:0] val;
    bit      growing;
    bit      noise;
    int      r;

    for (int i = 0; i < CAPACITY; i++) list_mem[i] = '0;
    list_len = 0;

    // empty list, position zero, insert past the end, value extremes
    dir_rows[0]  = dir_row(KIND_DELETE, 1, 32'h0000_0000, 1, 1'b0, 0);
    dir_rows[1]  = dir_row(KIND_INSERT, 0, 32'h0000_0005, 1, 1'b0, 0);
    dir_rows[2]  = dir_row(KIND_INSERT, 2, 32'h0000_0006, 1, 1'b0, 0);
    dir_rows[3]  = dir_row(KIND_INSERT, 1, 32'h8000_0000, 1, 1'b1, 1);
    dir_rows[4]  = dir_row(KIND_INSERT, 1, 32'h7FFF_FFFF, 1, 1'b1, 2);
    dir_rows[5]  = dir_row(KIND_INSERT, 3, 32'hFFFF_FFFF, 1, 1'b1, 3);
    dir_rows[6]  = dir_row(KIND_DELETE, 2, 32'hFFFF_FFFF, 0, 1'b0, 0);
    dir_rows[7]  = dir_row(KIND_DELETE, 3, 32'h0000_0000, 1, 1'b0, 2);
    dir_rows[8]  = dir_row(KIND_DELETE, 0, 32'h0000_0000, 1, 1'b0, 2);
    // fill to capacity at front, back and middle
    dir_rows[9]  = dir_row(KIND_INSERT, 1,  32'h1111_1111, 0, 1'b0, 0);
    dir_rows[10] = dir_row(KIND_INSERT, 4,  32'h2222_2222, 0, 1'b0, 0);
    dir_rows[11] = dir_row(KIND_INSERT, 2,  32'h3333_3333, 0, 1'b0, 0);
    dir_rows[12] = dir_row(KIND_INSERT, 6,  32'h4444_4444, 0, 1'b0, 0);
    dir_rows[13] = dir_row(KIND_INSERT, 3,  32'h5555_5555, 0, 1'b0, 0);
    dir_rows[14] = dir_row(KIND_INSERT, 8,  32'h6666_6666, 0, 1'b0, 0);
    dir_rows[15] = dir_row(KIND_INSERT, 1,  32'h7777_7777, 0, 1'b0, 0);
    dir_rows[16] = dir_row(KIND_INSERT, 10, 32'h8888_8888, 0, 1'b0, 0);
    dir_rows[17] = dir_row(KIND_INSERT, 5,  32'h9999_9999, 0, 1'b0, 0);
    dir_rows[18] = dir_row(KIND_INSERT, 12, 32'hAAAA_AAAA, 0, 1'b0, 0);
    dir_rows[19] = dir_row(KIND_INSERT, 7,  32'hBBBB_BBBB, 0, 1'b0, 0);
    dir_rows[20] = dir_row(KIND_INSERT, 14, 32'hCCCC_CCCC, 0, 1'b0, 0);
    dir_rows[21] = dir_row(KIND_INSERT, 15, 32'hDDDD_DDDD, 0, 1'b0, 0);
    dir_rows[22] = dir_row(KIND_INSERT, 9,  32'hEEEE_EEEE, 0, 1'b0, 0);
    // full list, largest position, delete the top slot
    dir_rows[23] = dir_row(KIND_INSERT, 17, 32'h0000_0001, 1, 1'b0, 16);
    dir_rows[24] = dir_row(KIND_DELETE, 31, 32'h0000_0000, 1, 1'b0, 16);
    dir_rows[25] = dir_row(KIND_DELETE, 16, 32'h0000_0000, 0, 1'b0, 0);

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      want = '0;
      want.accepted    = dir_rows[i].acc;
      want.count_after = dir_rows[i].cnt;
      send_op(dir_rows[i].kind, dir_rows[i].pos, dir_rows[i].val, dir_rows[i].typed, want);
    end

    // random part drifts the length up and down between empty and full
    growing = 1'b0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      no_gaps = (n >= 400 && n < 600);
      if (list_len >= CAPACITY) growing = 1'b0;
      else if (list_len == 0) growing = 1'b1;
      else if ($urandom_range(99) < 4) growing = !growing;

      r = $urandom_range(99);
      kind = growing ? ((r < 75) ? KIND_INSERT : KIND_DELETE)
                     : ((r < 75) ? KIND_DELETE : KIND_INSERT);
      noise = ($urandom_range(99) < 15);
      if (noise) pos = POS_W'($urandom_range(31, 0));
      else if (kind == KIND_INSERT) pos = POS_W'($urandom_range(list_len + 1, 1));
      else if (list_len > 0) pos = POS_W'($urandom_range(list_len, 1));
      else pos = 1;

      case ($urandom_range(39, 0))
        0: val = 32'h0000_0000;
        1: val = 32'h8000_0000;
        2: val = 32'h7FFF_FFFF;
        3: val = 32'hFFFF_FFFF;
        default: val = $urandom;
      endcase
      send_op(kind, pos, val, 1'b0, '0);
    end
    no_gaps = 1'b0;
    s_tvalid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
